FILE: src/nfa_pkg.sv
// Shared types and constants for the NFA to DFA subset builder.
package nfa_pkg;
  localparam int NfaStates = 32;
  localparam int DfaStates = 64;
  localparam int Symbols   = 16;
  localparam int NsDepth   = NfaStates * Symbols;

  typedef logic [NfaStates-1:0] nset_t;
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ADD    = 2'd0;
  localparam kind_t KIND_EXPAND = 2'd1;
  localparam kind_t KIND_CLEAR  = 2'd2;
endpackage

FILE: src/nfa_to_dfa_subset_builder.sv
// Top level of the NFA to DFA subset builder.
// Add item: a symbol search over the 16-entry list, then a next-set read, modify and
// write. Expand item: per symbol, one next-set read per NFA label (32) plus one subset
// memory read per stored subset (up to 64). Items are taken one at a time. After reset,
// and after a clear item, a clearing pass sweeps the next-set memory.
module nfa_to_dfa_subset_builder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_initial_state,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [4:0] in_from_state,
  input  logic [7:0] in_symbol,
  input  logic [4:0] in_to_state,
  input  logic       in_to_is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_dfa_from,
  output logic [7:0] out_out_symbol,
  output logic [5:0] out_dfa_to,
  output logic       out_dest_accepting,
  output logic       out_last,
  output logic       out_done_res,
  output logic       out_overflow
);
  import nfa_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ASRCH, S_ARD, S_AWR, S_XSTART, S_XOR, S_XORW,
    S_XSRCH, S_XSRCHW, S_XEMIT, S_OUT
  } st_t;

  st_t         st_r;
  logic [4:0]  init_r;
  logic [8:0]  clr_r;
  nset_t       seen_r, acc_r;
  logic [5:0]  scnt_r;
  logic [7:0]  syms_r [Symbols];
  logic [4:0]  symcnt_r;
  logic [6:0]  subcnt_r, xptr_r;
  logic        ovf_r;
  // latched item
  logic [4:0]  from_r, to_r;
  logic [7:0]  sym_r;
  logic [3:0]  sidx_r;
  logic        sfound_r;
  // expand working registers
  nset_t       cur_r, ns_r;
  logic [4:0]  sj_r;
  logic [5:0]  k_r;
  logic [6:0]  kk_r;
  logic [6:0]  kk_inc;
  logic [5:0]  dest_r;
  // output
  logic [5:0]  o_from_r, o_to_r;
  logic [7:0]  o_sym_r;
  logic        o_acc_r, o_last_r, o_done_r;

  // next-set memory
  nset_t       ns_mem [NsDepth];
  nset_t       ns_rd;
  logic [8:0]  ns_ra, ns_wa;
  logic        ns_we;
  nset_t       ns_wd;
  // subset memory
  nset_t       sub_mem [DfaStates];
  nset_t       sub_rd;
  logic [5:0]  sub_ra;
  logic        sub_we;
  logic [5:0]  sub_wa;

  nset_t lm, init_set;
  assign lm = (scnt_r[5]) ? '1 : ((nset_t'(1) << scnt_r[4:0]) - nset_t'(1));
  assign init_set = nset_t'(1) << init_r;

  always_ff @(posedge clk) begin
    if (ns_we) ns_mem[ns_wa] <= ns_wd;
    ns_rd <= ns_mem[ns_ra];
    if (sub_we) sub_mem[sub_wa] <= ns_r;
    sub_rd <= sub_mem[sub_ra];
  end

  // next-set read address and write control
  always_comb begin
    ns_ra = {from_r, sidx_r};
    if (st_r == S_XOR || st_r == S_XORW) ns_ra = {k_r[4:0], sj_r[3:0]};
    ns_we = 1'b0;
    ns_wa = {from_r, sidx_r};
    ns_wd = ns_rd | (nset_t'(1) << to_r);
    if (st_r == S_CLR) begin
      ns_we = 1'b1;
      ns_wa = clr_r;
      ns_wd = '0;
    end else if (st_r == S_AWR) begin
      ns_we = 1'b1;
    end
  end

  // During the search the subset memory is addressed one entry ahead of kk_r, so that
  // sub_rd holds entry kk_r in every compare cycle.
  assign kk_inc = kk_r + 7'd1;
  assign sub_ra = (st_r == S_XSRCHW) ? kk_inc[5:0] : kk_r[5:0];
  assign sub_we = (st_r == S_XEMIT) && !sfound_r && (subcnt_r < 7'(DfaStates));
  assign sub_wa = subcnt_r[5:0];

  assign in_ready  = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (st_r == S_OUT);
  assign out_dfa_from = o_from_r;
  assign out_out_symbol = o_sym_r;
  assign out_dfa_to = o_to_r;
  assign out_dest_accepting = o_acc_r;
  assign out_last = o_last_r;
  assign out_done_res = o_done_r;
  assign out_overflow = ovf_r;

  nset_t sub_cmp;
  assign sub_cmp = sub_rd & lm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; init_r <= '0; clr_r <= '0;
      seen_r <= '0; acc_r <= '0; scnt_r <= '0; symcnt_r <= '0;
      subcnt_r <= 7'd1; xptr_r <= '0; ovf_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) init_r <= cfg_initial_state;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 9'd1;
          if (clr_r == 9'(NsDepth - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          from_r <= in_from_state; to_r <= in_to_state; sym_r <= in_symbol;
          if (in_kind == KIND_ADD) begin
            seen_r <= seen_r | (nset_t'(1) << in_from_state)
                             | (nset_t'(1) << in_to_state);
            scnt_r <= scnt_r + 6'(!seen_r[in_from_state])
                    + 6'(!seen_r[in_to_state] && in_to_state != in_from_state);
            if (in_to_is_final) acc_r <= acc_r | (nset_t'(1) << in_to_state);
            sj_r <= '0; sfound_r <= 1'b0;
            st_r <= S_ASRCH;
          end else if (in_kind == KIND_EXPAND) begin
            st_r <= S_XSTART;
          end else if (in_kind == KIND_CLEAR) begin
            seen_r <= '0; acc_r <= '0; scnt_r <= '0; symcnt_r <= '0;
            subcnt_r <= 7'd1; xptr_r <= '0; ovf_r <= 1'b0; clr_r <= '0;
            st_r <= S_CLR;
          end
        end
        S_ASRCH: begin
          if (sj_r < symcnt_r && syms_r[sj_r[3:0]] == sym_r) begin
            sidx_r <= sj_r[3:0]; st_r <= S_ARD;
          end else if (sj_r >= symcnt_r) begin
            if (symcnt_r < 5'(Symbols)) begin
              syms_r[symcnt_r[3:0]] <= sym_r;
              sidx_r <= symcnt_r[3:0];
              symcnt_r <= symcnt_r + 5'd1;
              st_r <= S_ARD;
            end else begin
              ovf_r <= 1'b1; st_r <= S_IDLE;
            end
          end else sj_r <= sj_r + 5'd1;
        end
        S_ARD: st_r <= S_AWR;
        S_AWR: st_r <= S_IDLE;
        S_XSTART: begin
          if (xptr_r >= subcnt_r) begin
            o_from_r <= '0; o_sym_r <= '0; o_to_r <= '0; o_acc_r <= 1'b0;
            o_last_r <= 1'b1; o_done_r <= 1'b1; st_r <= S_OUT;
          end else if (symcnt_r == 5'd0) begin
            xptr_r <= xptr_r + 7'd1; st_r <= S_IDLE;
          end else begin
            kk_r <= xptr_r; sj_r <= '0; st_r <= S_XORW;
          end
        end
        // wait state to read the subset being expanded
        S_XORW: begin
          k_r <= '0; ns_r <= '0; st_r <= S_XOR;
        end
        S_XOR: begin
          if (k_r == 6'd0) cur_r <= ((kk_r == 7'd0) ? init_set : sub_rd) & lm;
          // the read for label k_r returns next cycle; accumulate label k_r-1
          if (k_r != 6'd0 && cur_r[k_r[4:0] - 5'd1]) ns_r <= ns_r | ns_rd;
          if (k_r == 6'(NfaStates)) begin
            kk_r <= 7'd1; st_r <= S_XSRCH; dest_r <= '0; sfound_r <= 1'b0;
          end else k_r <= k_r + 6'd1;
        end
        S_XSRCH: begin
          ns_r <= ns_r & lm;
          if ((init_set & lm) == (ns_r & lm)) begin
            sfound_r <= 1'b1; dest_r <= '0; st_r <= S_XEMIT;
          end else if (subcnt_r == 7'd1) st_r <= S_XEMIT;
          else st_r <= S_XSRCHW;
        end
        S_XSRCHW: begin
          // sub_rd now holds entry kk_r
          if (sub_cmp == ns_r) begin
            sfound_r <= 1'b1; dest_r <= kk_r[5:0]; st_r <= S_XEMIT;
          end else if (kk_inc >= subcnt_r) begin
            st_r <= S_XEMIT;
          end else kk_r <= kk_inc;
        end
        S_XEMIT: begin
          if (!sfound_r) begin
            if (subcnt_r < 7'(DfaStates)) begin
              dest_r <= subcnt_r[5:0];
              o_to_r <= subcnt_r[5:0];
              subcnt_r <= subcnt_r + 7'd1;
            end else begin
              ovf_r <= 1'b1; o_to_r <= '0;
            end
          end else o_to_r <= dest_r;
          o_from_r <= xptr_r[5:0];
          o_sym_r <= syms_r[sj_r[3:0]];
          o_acc_r <= |(ns_r & acc_r);
          o_last_r <= (sj_r + 5'd1 == symcnt_r);
          o_done_r <= 1'b0;
          st_r <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          if (o_done_r) st_r <= S_IDLE;
          else if (o_last_r) begin
            xptr_r <= xptr_r + 7'd1; st_r <= S_IDLE;
          end else begin
            sj_r <= sj_r + 5'd1; kk_r <= xptr_r; k_r <= 6'd32;
            st_r <= S_XORW;
          end
        end
        default: st_r <= S_IDLE;
      endcase
      // compare address starts one ahead of the compare in S_XSRCH
      if (st_r == S_XSRCH) kk_r <= 7'd1;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_ready == 1'b0)
    else $error("input taken while a result waits");
  assert property (@(posedge clk) disable iff (!rst_n) subcnt_r <= 7'(DfaStates))
    else $error("subset count beyond table");
  assert property (@(posedge clk) disable iff (!rst_n) symcnt_r <= 5'(Symbols))
    else $error("symbol count beyond table");
endmodule
